// ----- src/apq_pkg.sv -----
`default_nettype none

package apq_pkg;

    localparam int DEPTH_DEF = 8;

    localparam int PRIO_W    = 8;
    localparam int VALUE_W   = 16;
    localparam int STATUS_W  = 2;
    localparam int ENTRY_W   = PRIO_W + VALUE_W;

    // Stream payload widths, rounded up to whole bytes.
    localparam int S_TDATA_W = ((PRIO_W + VALUE_W + 7) / 8) * 8;
    localparam int S_TUSER_W = 1;
    localparam int M_FIELD_W = STATUS_W + PRIO_W + VALUE_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - M_FIELD_W;

    typedef enum logic [S_TUSER_W-1:0] {
        REQ_INSERT = 1'b0,
        REQ_REMOVE = 1'b1
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_REMOVED  = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

endpackage

`default_nettype wire

// ----- src/apq_ram.sv -----
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module apq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- src/array_priority_queue.sv -----
`default_nettype none

// Fixed-capacity priority queue of DEPTH (priority, value) pairs kept in arrival
// order in one RAM. An insert transaction (tuser 0) appends the pair at the tail
// and answers in the next cycle with status inserted, or full when all DEPTH
// slots are taken. A remove transaction (tuser 1) scans the occupied slots one
// RAM read per cycle with a single comparator, keeping the earliest entry of the
// highest priority, then moves every later entry down one slot, one read and one
// write per cycle, and returns the pair with status removed; on an empty queue it
// answers at once with status empty. The length of a remove grows with the number
// of stored entries and of entries behind the chosen one, bounded by the single
// RAM read port, and the result then waits until the output register is free.
// The input is not ready while a remove is in progress. One result waits in an
// output register, and the next transaction is accepted while it is taken.
module array_priority_queue #(
    parameter int DEPTH = apq_pkg::DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // [7:0] in_priority, [23:8] in_value
    input  wire logic [apq_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [0] req_type
    input  wire logic [apq_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [1:0] status, [9:2] out_priority, [25:10] out_value, [31:26] zero
    output logic      [apq_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    import apq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state               r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_ridx,  n_ridx;
    logic                 r_dv,    n_dv;
    logic [AW-1:0]        r_didx,  n_didx;
    logic [AW-1:0]        r_best_slot, n_best_slot;
    logic [PRIO_W-1:0]    r_best_prio, n_best_prio;
    logic [VALUE_W-1:0]   r_best_val,  n_best_val;
    logic                 r_out_valid, n_out_valid;
    t_status              r_out_status, n_out_status;
    logic [PRIO_W-1:0]    r_out_prio,   n_out_prio;
    logic [VALUE_W-1:0]   r_out_val,    n_out_val;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;

    logic                 s_accept;
    logic                 out_free;
    t_req                 req;
    logic [PRIO_W-1:0]    in_prio;
    logic [VALUE_W-1:0]   in_val;
    logic [PRIO_W-1:0]    rd_prio;
    logic [VALUE_W-1:0]   rd_val;

    assign req      = t_req'(s_axis_tuser[0]);
    assign in_prio  = s_axis_tdata[PRIO_W-1:0];
    assign in_val   = s_axis_tdata[PRIO_W +: VALUE_W];
    assign rd_prio  = ram_rdata[PRIO_W-1:0];
    assign rd_val   = ram_rdata[PRIO_W +: VALUE_W];

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && out_free;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    apq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_ridx       = r_ridx;
        n_dv         = 1'b0;
        n_didx       = r_didx;
        n_best_slot  = r_best_slot;
        n_best_prio  = r_best_prio;
        n_best_val   = r_best_val;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_status = r_out_status;
        n_out_prio   = r_out_prio;
        n_out_val    = r_out_val;
        ram_we       = 1'b0;
        ram_waddr    = r_count[AW-1:0];
        ram_wdata    = {in_val, in_prio};
        ram_re       = 1'b0;
        ram_raddr    = r_ridx[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_out_prio = '0;
                    n_out_val  = '0;
                    if (req == REQ_INSERT) begin
                        n_out_valid = 1'b1;
                        if (r_count == CW'(DEPTH)) begin
                            n_out_status = ST_FULL;
                        end else begin
                            ram_we       = 1'b1;
                            n_count      = r_count + CW'(1);
                            n_out_status = ST_INSERTED;
                        end
                    end else if (r_count == '0) begin
                        n_out_valid  = 1'b1;
                        n_out_status = ST_EMPTY;
                    end else begin
                        n_ridx  = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // The first slot seeds the maximum; a strict compare keeps the
                // earliest entry among equal priorities.
                if (r_dv && (r_didx == '0 || rd_prio > r_best_prio)) begin
                    n_best_slot = r_didx;
                    n_best_prio = rd_prio;
                    n_best_val  = rd_val;
                end
                if (r_ridx < r_count) begin
                    ram_re = 1'b1;
                    n_ridx = r_ridx + CW'(1);
                    n_dv   = 1'b1;
                    n_didx = r_ridx[AW-1:0];
                end else if (!r_dv) begin
                    n_ridx  = CW'(r_best_slot) + CW'(1);
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                // Entry read from slot k + 1 last cycle is written to slot k.
                if (r_dv) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_didx - AW'(1);
                    ram_wdata = ram_rdata;
                end
                if (r_ridx < r_count) begin
                    ram_re = 1'b1;
                    n_ridx = r_ridx + CW'(1);
                    n_dv   = 1'b1;
                    n_didx = r_ridx[AW-1:0];
                end else if (!r_dv) begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_REMOVED;
                    n_out_prio   = r_best_prio;
                    n_out_val    = r_best_val;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dv        <= n_dv;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ridx       <= n_ridx;
        r_didx       <= n_didx;
        r_best_slot  <= n_best_slot;
        r_best_prio  <= n_best_prio;
        r_best_val   <= n_best_val;
        r_out_status <= n_out_status;
        r_out_prio   <= n_out_prio;
        r_out_val    <= n_out_val;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{M_PAD_W{1'b0}}, r_out_val, r_out_prio, r_out_status};

endmodule

`default_nettype wire

// ----- src/apq_checker.sv -----
`default_nettype none

module apq_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    input  wire logic                          s_axis_tready,
    input  wire logic [apq_pkg::S_TUSER_W-1:0] s_axis_tuser,
    input  wire logic                          m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    input  wire logic [apq_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    import apq_pkg::*;

    logic          s_accept;
    logic [1:0]    m_status;

    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign m_status = m_axis_tdata[STATUS_W-1:0];

    // A result that is stalled keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // A new transaction is taken only when the output register can accept its result.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready && m_axis_tvalid |-> m_axis_tready)
        else $error("input ready while output register is blocked");

    // Only a removed entry carries a priority and a value.
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_status != ST_REMOVED |->
            m_axis_tdata[M_TDATA_W-1:STATUS_W] == '0)
        else $error("nonzero payload on a result without an entry");

    // An insert is answered in the next cycle.
    a_insert_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && s_axis_tuser[0] == REQ_INSERT |=>
            m_axis_tvalid && (m_status == ST_INSERTED || m_status == ST_FULL))
        else $error("insert not answered in the next cycle");

    // A remove either answers empty at once or holds the input off while it works.
    a_remove_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && s_axis_tuser[0] == REQ_REMOVE |=>
            (m_axis_tvalid && m_status == ST_EMPTY) || !s_axis_tready)
        else $error("remove neither empty nor busy");

endmodule

bind array_priority_queue apq_checker u_apq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
